### hw/rtl/periodic_task_tick_scheduler_defines.svh
// Assertion helpers shared by the scheduler RTL.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH

// Property must hold on every clock edge outside reset.
`define PTTS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define PTTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ptts_pkg.sv
package ptts_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int CFG_WIDTH           = 16;
    localparam int CFG_INDEX_WIDTH     = 3;
    localparam int LEVEL_WIDTH         = 16;
    localparam int TOGGLE_WIDTH        = 16;
    localparam int REQ_WIDTH           = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MEASURE_PERIOD  = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SENSOR_VALVE_ON = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SENSOR_VALVE_OFF = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SENSOR_FAST     = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SENSOR_EXERCISE = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ALT_INTERVAL    = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_AUTO_EXIT       = 3'd6;

    // Operation codes
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Status request codes
    localparam logic [REQ_WIDTH-1:0] REQ_NONE    = 2'd0;
    localparam logic [REQ_WIDTH-1:0] REQ_MEASURE = 2'd1;
    localparam logic [REQ_WIDTH-1:0] REQ_SENSOR  = 2'd2;

    // Separation applied when the two schedule countdowns collide
    localparam int COLLIDE_SENSOR_STEP  = 2;
    localparam int COLLIDE_MEASURE_STEP = 4;

endpackage

### hw/rtl/periodic_task_tick_scheduler.sv
// Periodic task tick scheduler.
// Input channel (in_valid/in_ready) takes one word per wake-up tick or
// auto-exit restart, with the mode flags and the current level value.
// Output channel (out_valid/out_ready) returns exactly one result word per
// input word: status request, display draw flags, level to draw and the
// auto-exit expired flag.
// Config channel (cfg_valid/cfg_ready) writes the seven 16-bit period
// registers by index; it is always ready. Indexes past the list are dropped.
// The result of a word accepted at an edge is registered at that same edge.
// Throughput is one word per cycle while out_ready is high; all countdown updates,
// reloads and the display decision are done in a single pass into the
// state and output registers.
// The output register decouples the two sides: a new word is taken while a
// result waits, as long as out_ready is high; when the receiver stalls,
// the result holds and in_ready drops.
// Reset clears all config registers, loads the sensor countdown with zero,
// the measurement countdown with one, and forces the next level draw.
module periodic_task_tick_scheduler #(
    parameter int COUNT_WIDTH = ptts_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ptts_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [ptts_pkg::CFG_WIDTH-1:0]        cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  operation,
    input  logic                                  paused,
    input  logic                                  exercise_mode,
    input  logic                                  fast_poll,
    input  logic                                  valve_open,
    input  logic                                  low_temp_armed,
    input  logic [ptts_pkg::LEVEL_WIDTH-1:0]      level_value,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [ptts_pkg::REQ_WIDTH-1:0]        status_request,
    output logic                                  show_low,
    output logic                                  show_level,
    output logic [ptts_pkg::LEVEL_WIDTH-1:0]      shown_level,
    output logic                                  auto_exit_expired
);

    import ptts_pkg::*;

    `include "periodic_task_tick_scheduler_defines.svh"

    // config registers
    logic [CFG_WIDTH-1:0] measure_period_reg;
    logic [CFG_WIDTH-1:0] sensor_on_reg;
    logic [CFG_WIDTH-1:0] sensor_off_reg;
    logic [CFG_WIDTH-1:0] sensor_fast_reg;
    logic [CFG_WIDTH-1:0] sensor_exercise_reg;
    logic [CFG_WIDTH-1:0] alt_interval_reg;
    logic [CFG_WIDTH-1:0] auto_exit_reg;

    // schedule state
    logic [COUNT_WIDTH-1:0]  sensor_cnt_reg,  sensor_cnt_next;
    logic [COUNT_WIDTH-1:0]  measure_cnt_reg, measure_cnt_next;
    logic [COUNT_WIDTH-1:0]  exit_cnt_reg,    exit_cnt_next;
    logic                    indicating_low_reg, indicating_low_next;
    logic [TOGGLE_WIDTH-1:0] toggle_ticks_reg, toggle_ticks_next;
    logic [LEVEL_WIDTH-1:0]  last_level_reg,  last_level_next;
    logic                    redraw_reg,      redraw_next;

    // output register
    logic                    out_valid_reg;
    logic [REQ_WIDTH-1:0]    request_reg,     request_next;
    logic                    show_low_reg,    show_low_next;
    logic                    show_level_reg,  show_level_next;
    logic [LEVEL_WIDTH-1:0]  shown_level_reg, shown_level_next;
    logic                    expired_reg,     expired_next;

    logic in_accept;
    logic cfg_accept;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid & cfg_ready;
    assign in_ready   = ~out_valid_reg | out_ready;
    assign in_accept  = in_valid & in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            measure_period_reg  <= '0;
            sensor_on_reg       <= '0;
            sensor_off_reg      <= '0;
            sensor_fast_reg     <= '0;
            sensor_exercise_reg <= '0;
            alt_interval_reg    <= '0;
            auto_exit_reg       <= '0;
        end
        else if (cfg_accept)
        begin
            unique case (cfg_index)
                CFG_MEASURE_PERIOD:   measure_period_reg  <= cfg_data;
                CFG_SENSOR_VALVE_ON:  sensor_on_reg       <= cfg_data;
                CFG_SENSOR_VALVE_OFF: sensor_off_reg      <= cfg_data;
                CFG_SENSOR_FAST:      sensor_fast_reg     <= cfg_data;
                CFG_SENSOR_EXERCISE:  sensor_exercise_reg <= cfg_data;
                CFG_ALT_INTERVAL:     alt_interval_reg    <= cfg_data;
                CFG_AUTO_EXIT:        auto_exit_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic [COUNT_WIDTH-1:0] s_dec;
        logic [COUNT_WIDTH-1:0] m_dec;
        logic [COUNT_WIDTH-1:0] s_rel;
        logic [COUNT_WIDTH-1:0] m_rel;
        logic [CFG_WIDTH-1:0]   sensor_period;

        sensor_cnt_next     = sensor_cnt_reg;
        measure_cnt_next    = measure_cnt_reg;
        exit_cnt_next       = exit_cnt_reg;
        indicating_low_next = indicating_low_reg;
        toggle_ticks_next   = toggle_ticks_reg;
        last_level_next     = last_level_reg;
        redraw_next         = redraw_reg;

        request_next     = REQ_NONE;
        show_low_next    = 1'b0;
        show_level_next  = 1'b0;
        shown_level_next = '0;

        s_dec = (sensor_cnt_reg  != '0) ? sensor_cnt_reg  - COUNT_WIDTH'(1) : '0;
        m_dec = (measure_cnt_reg != '0) ? measure_cnt_reg - COUNT_WIDTH'(1) : '0;
        s_rel = s_dec;
        m_rel = m_dec;

        if (exercise_mode)
            sensor_period = sensor_exercise_reg;
        else if (fast_poll)
            sensor_period = sensor_fast_reg;
        else if (valve_open)
            sensor_period = sensor_on_reg;
        else
            sensor_period = sensor_off_reg;

        if (operation == OP_RESTART)
        begin
            exit_cnt_next = COUNT_WIDTH'(auto_exit_reg);
        end
        else
        begin
            exit_cnt_next = (exit_cnt_reg != '0) ? exit_cnt_reg - COUNT_WIDTH'(1) : '0;

            if (!paused)
            begin
                if (m_dec == '0)
                begin
                    m_rel        = COUNT_WIDTH'(measure_period_reg);
                    request_next = REQ_MEASURE;
                end
                // sensor poll overrides a measurement request
                if (s_dec == '0)
                begin
                    s_rel        = COUNT_WIDTH'(sensor_period);
                    request_next = REQ_SENSOR;
                end
            end

            if (s_rel == m_rel)
            begin
                sensor_cnt_next  = s_rel + COUNT_WIDTH'(COLLIDE_SENSOR_STEP);
                measure_cnt_next = m_rel + COUNT_WIDTH'(COLLIDE_MEASURE_STEP);
            end
            else
            begin
                sensor_cnt_next  = s_rel;
                measure_cnt_next = m_rel;
            end

            if (low_temp_armed)
            begin
                if (indicating_low_reg)
                begin
                    show_low_next = (toggle_ticks_reg == '0);
                end
                else if (redraw_reg || (last_level_reg != level_value))
                begin
                    show_level_next  = 1'b1;
                    shown_level_next = level_value;
                    last_level_next  = level_value;
                    redraw_next      = 1'b0;
                end

                if (toggle_ticks_reg > alt_interval_reg)
                begin
                    indicating_low_next = ~indicating_low_reg;
                    toggle_ticks_next   = '0;
                    // leaving the LOW phase: level must be drawn again
                    if (indicating_low_reg)
                        redraw_next = 1'b1;
                end
                else
                begin
                    toggle_ticks_next = toggle_ticks_reg + TOGGLE_WIDTH'(1);
                end
            end
        end

        expired_next = (exit_cnt_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_cnt_reg     <= '0;
            measure_cnt_reg    <= COUNT_WIDTH'(1);
            exit_cnt_reg       <= '0;
            indicating_low_reg <= 1'b0;
            toggle_ticks_reg   <= '0;
            last_level_reg     <= '0;
            redraw_reg         <= 1'b1;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                sensor_cnt_reg     <= sensor_cnt_next;
                measure_cnt_reg    <= measure_cnt_next;
                exit_cnt_reg       <= exit_cnt_next;
                indicating_low_reg <= indicating_low_next;
                toggle_ticks_reg   <= toggle_ticks_next;
                last_level_reg     <= last_level_next;
                redraw_reg         <= redraw_next;
                out_valid_reg      <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result word, loaded only when a new word is taken
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            request_reg     <= request_next;
            show_low_reg    <= show_low_next;
            show_level_reg  <= show_level_next;
            shown_level_reg <= shown_level_next;
            expired_reg     <= expired_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status_request    = request_reg;
    assign show_low          = show_low_reg;
    assign show_level        = show_level_reg;
    assign shown_level       = shown_level_reg;
    assign auto_exit_expired = expired_reg;

    // the collision rule keeps the two schedules apart at all times
    `PTTS_ASSERT(a_sched_apart, clk, rst_n, sensor_cnt_reg != measure_cnt_reg,
        "sensor and measurement countdowns coincide")

    `PTTS_ASSERT(a_draw_exclusive, clk, rst_n,
        !(out_valid_reg && show_low_reg && show_level_reg),
        "LOW indication and level drawn together")

    `PTTS_ASSERT(a_level_zero, clk, rst_n,
        !(out_valid_reg && !show_level_reg && (shown_level_reg != '0)),
        "level value present without a draw")

    `PTTS_ASSERT_NEXT(a_restart_quiet, clk, rst_n,
        in_accept && (operation == OP_RESTART),
        out_valid_reg && (request_reg == REQ_NONE) && !show_low_reg && !show_level_reg,
        "restart word produced a request or a draw")

    `PTTS_ASSERT_NEXT(a_restart_expiry, clk, rst_n,
        in_accept && (operation == OP_RESTART),
        expired_reg == (exit_cnt_reg == '0),
        "expired flag does not match auto-exit countdown")

endmodule
